@@ src/sorted_linked_list_insert_core_macros.svh @@
// assertion macros for the sorted linked list insert core
// no dependencies; included by files that carry concurrent assertions
`ifndef SORTED_LINKED_LIST_INSERT_CORE_MACROS_SVH
`define SORTED_LINKED_LIST_INSERT_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define SLLI_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slli assertion failed");
// next-cycle implication
`define SLLI_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slli assertion failed");
`else
`define SLLI_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define SLLI_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

@@ src/slli_pkg.sv @@
// shared types and constants for the sorted linked list insert core
// no dependencies
package slli_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int KEY_BYTES_DEF = 8;
  localparam int KEY_W         = 64;
  localparam int PAYLOAD_W     = 32;
  localparam int SLOT_W        = 4;
  localparam int MAX_RESULTS   = 16;

  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_READOUT = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_ENTRY    = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    status_t                status;
    logic [SLOT_W-1:0]      slot;
    logic [KEY_W-1:0]       entry_key;
    logic [PAYLOAD_W-1:0]   entry_payload;
    logic                   last;
  } result_t;

endpackage

@@ src/slli_if.sv @@
// request and response channel interfaces (valid/ready)
// depends on slli_pkg
interface slli_req_if;
  import slli_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [KEY_W-1:0]     key;
  logic [PAYLOAD_W-1:0] payload;
  modport source (output valid, req_type, key, payload, input ready);
  modport sink (input valid, req_type, key, payload, output ready);
endinterface

interface slli_rsp_if;
  import slli_pkg::*;
  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [SLOT_W-1:0]    slot;
  logic [KEY_W-1:0]     entry_key;
  logic [PAYLOAD_W-1:0] entry_payload;
  logic                 last;
  modport source (output valid, status, slot, entry_key, entry_payload, last, input ready);
  modport sink (input valid, status, slot, entry_key, entry_payload, last, output ready);
endinterface

@@ src/sorted_linked_list_insert_core.sv @@
// sorted linked list table: insert in key order and ordered readout
// depends on slli_pkg, slli_if, slli_ram and the assertion macro header
//
//   channel  dir  type         contents
//   req      in   slli_req_if  req_type, key, payload
//   rsp      out  slli_rsp_if  status, slot, entry_key, entry_payload, last
//
// insert: after the accept, a walk that steps past each entry with a smaller
//   key, paced by the dependent link-memory read per walk step, then a link
//   write for the new slot and, unless it becomes the head, one for its predecessor
// readout: after the accept, one result per cycle while rsp is ready
// reset empties the chain at once; the memories need no clearing
// a stalled rsp holds the core where it has a result to load; req is taken only when idle
`include "sorted_linked_list_insert_core_macros.svh"
module sorted_linked_list_insert_core #(
  parameter int CAPACITY  = slli_pkg::CAPACITY_DEF,
  parameter int KEY_BYTES = slli_pkg::KEY_BYTES_DEF
) (
  input logic      clk,
  input logic      rst,
  slli_req_if.sink   req,
  slli_rsp_if.source rsp
);
  import slli_pkg::*;

  localparam int SLOT_IDX_W  = $clog2(CAPACITY);
  localparam int LINK_W      = SLOT_IDX_W + 1;
  localparam int COUNT_W     = $clog2(CAPACITY + 1);
  localparam int KEY_STORE_W = 8 * KEY_BYTES;
  localparam int DATA_W      = KEY_STORE_W + PAYLOAD_W;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS);
  localparam logic [LINK_W-1:0] END_LINK = {LINK_W{1'b1}};

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_WALK      = 5'b00010,
    S_LINK_NEW  = 5'b00100,
    S_LINK_PREV = 5'b01000,
    S_READ      = 5'b10000
  } state_t;

  state_t                  state, state_next;
  logic [LINK_W-1:0]       cur, cur_next;
  logic [LINK_W-1:0]       prev;
  logic [LINK_W-1:0]       head;
  logic [COUNT_W-1:0]      count;
  logic [RES_CNT_W-1:0]    n;
  logic [KEY_STORE_W-1:0]  new_key;
  logic                    out_valid;
  result_t                 res, res_next;
  logic                    load;

  logic                    can_load;
  logic                    accept;
  logic                    full;
  logic [SLOT_IDX_W-1:0]   slot_idx;
  logic [KEY_STORE_W-1:0]  req_key;
  logic                    data_we;
  logic [DATA_W-1:0]       data_rdata;
  logic [KEY_STORE_W-1:0]  key_rd;
  logic [PAYLOAD_W-1:0]    payload_rd;
  logic                    link_we;
  logic [SLOT_IDX_W-1:0]   link_waddr;
  logic [LINK_W-1:0]       link_wdata;
  logic [LINK_W-1:0]       link_rdata;
  logic                    walk_on;
  logic                    read_last;

  assign can_load   = !out_valid || rsp.ready;
  assign req.ready  = (state == S_IDLE) && can_load;
  assign accept     = req.valid && req.ready;
  assign full       = (count == COUNT_W'(CAPACITY));
  assign slot_idx   = count[SLOT_IDX_W-1:0];
  assign req_key    = req.key[KEY_W-1 -: KEY_STORE_W];
  assign key_rd     = data_rdata[DATA_W-1 -: KEY_STORE_W];
  assign payload_rd = data_rdata[PAYLOAD_W-1:0];
  // read data always belongs to the slot held in cur
  assign walk_on    = (cur != END_LINK) && (key_rd < new_key);
  assign read_last  = (link_rdata == END_LINK) || (n == RES_CNT_W'(MAX_RESULTS - 1));

  slli_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (slot_idx),
    .wdata ({req_key, req.payload}),
    .raddr (cur_next[SLOT_IDX_W-1:0]),
    .rdata (data_rdata)
  );

  slli_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (cur_next[SLOT_IDX_W-1:0]),
    .rdata (link_rdata)
  );

  always_comb begin
    state_next = state;
    cur_next   = cur;
    data_we    = 1'b0;
    link_we    = 1'b0;
    link_waddr = slot_idx;
    link_wdata = cur;
    load       = 1'b0;
    res_next   = '{status: ST_INSERTED, slot: '0, entry_key: '0, entry_payload: '0,
                   last: 1'b1};
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.req_type == REQ_INSERT) begin
            if (full) begin
              load            = 1'b1;
              res_next.status = ST_FULL;
            end else begin
              data_we    = 1'b1;
              cur_next   = head;
              state_next = S_WALK;
            end
          end else begin
            if (head == END_LINK) begin
              load            = 1'b1;
              res_next.status = ST_EMPTY;
            end else begin
              cur_next   = head;
              state_next = S_READ;
            end
          end
        end
      end
      S_WALK: begin
        if (walk_on) begin
          cur_next = link_rdata;
        end else begin
          state_next = S_LINK_NEW;
        end
      end
      S_LINK_NEW: begin
        link_we = 1'b1;
        if (prev == END_LINK) begin
          if (can_load) begin
            load          = 1'b1;
            res_next.slot = SLOT_W'(slot_idx);
            state_next    = S_IDLE;
          end
        end else begin
          state_next = S_LINK_PREV;
        end
      end
      S_LINK_PREV: begin
        link_we    = 1'b1;
        link_waddr = prev[SLOT_IDX_W-1:0];
        link_wdata = {1'b0, slot_idx};
        if (can_load) begin
          load          = 1'b1;
          res_next.slot = SLOT_W'(slot_idx);
          state_next    = S_IDLE;
        end
      end
      S_READ: begin
        if (can_load) begin
          load                   = 1'b1;
          res_next.status        = ST_ENTRY;
          res_next.slot          = SLOT_W'(cur[SLOT_IDX_W-1:0]);
          res_next.entry_key     = KEY_W'(key_rd) << (KEY_W - KEY_STORE_W);
          res_next.entry_payload = payload_rd;
          res_next.last          = read_last;
          if (read_last) begin
            state_next = S_IDLE;
          end else begin
            cur_next = link_rdata;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= END_LINK;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      // insert commits when its result is loaded
      if (load && (state == S_LINK_NEW || state == S_LINK_PREV)) begin
        count <= count + 1'b1;
        if (state == S_LINK_NEW) begin
          head <= {1'b0, slot_idx};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (load) begin
      res <= res_next;
    end
    if (accept) begin
      new_key <= req_key;
      prev    <= END_LINK;
      n       <= '0;
    end else if (state == S_WALK && walk_on) begin
      prev <= cur;
    end else if (state == S_READ && load) begin
      n <= n + 1'b1;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = res.status;
  assign rsp.slot          = res.slot;
  assign rsp.entry_key     = res.entry_key;
  assign rsp.entry_payload = res.entry_payload;
  assign rsp.last          = res.last;

  `SLLI_ASSERT_NEXT(a_count_step, clk, rst, state == S_LINK_PREV && can_load, count == $past(count) + 1'b1)
  `SLLI_ASSERT_IMPLY(a_walk_not_full, clk, rst, state == S_WALK, count != COUNT_W'(CAPACITY))
  `SLLI_ASSERT_IMPLY(a_read_bounded, clk, rst, state == S_READ, n < count && head != END_LINK)

endmodule

@@ src/slli_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module slli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sim/sorted_linked_list_insert_check.sv @@
`timescale 1ns / 100ps
// checker for the sorted linked list insert core: keeps a shadow of the table,
// predicts every response from the accepted requests and compares them in order
// depends on slli_pkg and slli_if
module sorted_linked_list_insert_check (
  input  logic clk,
  input  logic rst,
  slli_req_if  req,
  slli_rsp_if  rsp,
  output int   fail_count,
  output int   pending
);
  import slli_pkg::*;

  localparam int         CAP      = CAPACITY_DEF;
  localparam int         IDX_W    = $clog2(CAP);
  localparam logic [4:0] END_SLOT = 5'h1f;
  localparam logic [KEY_W-1:0] KEY_MASK =
    ~((64'd1 << (8 * (8 - KEY_BYTES_DEF))) - 64'd1);

  logic [KEY_W-1:0]     table_key     [CAP];
  logic [PAYLOAD_W-1:0] table_payload [CAP];
  logic [4:0]           table_link    [CAP];
  logic [4:0]           head;
  int                   entry_total;
  result_t              expected_rsp_q[$];
  int                   mismatch_total = 0;

  task automatic report_mismatch(input string msg);
    if (mismatch_total < 40) $display("mismatch: %s", msg);
    mismatch_total++;
  endtask

  task automatic predict_insert(input logic [KEY_W-1:0] key_in,
                                input logic [PAYLOAD_W-1:0] payload_in);
    logic [KEY_W-1:0] k;
    logic [4:0]       prev;
    logic [4:0]       cur;
    logic [4:0]       slot;
    int               steps;
    result_t          r;
    k = key_in & KEY_MASK;
    r = '0;
    r.last = 1'b1;
    if (entry_total >= CAP) begin
      r.status = ST_FULL;
    end else begin
      slot = entry_total[4:0];
      table_key[slot[IDX_W-1:0]] = k;
      table_payload[slot[IDX_W-1:0]] = payload_in;
      prev = END_SLOT;
      cur = head;
      steps = 0;
      // stop at the first entry whose key is not smaller, so a new key goes ahead of equal keys
      while (cur < CAP && steps < entry_total && table_key[cur[IDX_W-1:0]] < k) begin
        prev = cur;
        cur = table_link[cur[IDX_W-1:0]];
        steps++;
      end
      if (prev == END_SLOT) begin
        table_link[slot[IDX_W-1:0]] = head;
        head = slot;
      end else begin
        table_link[slot[IDX_W-1:0]] = table_link[prev[IDX_W-1:0]];
        table_link[prev[IDX_W-1:0]] = slot;
      end
      entry_total++;
      r.status = ST_INSERTED;
      r.slot = slot[SLOT_W-1:0];
    end
    expected_rsp_q.push_back(r);
  endtask

  task automatic predict_readout();
    logic [4:0] cur;
    logic [4:0] nxt;
    int         steps;
    int         n;
    result_t    r;
    r = '0;
    if (head >= CAP || entry_total == 0) begin
      r.status = ST_EMPTY;
      r.last = 1'b1;
      expected_rsp_q.push_back(r);
    end else begin
      cur = head;
      steps = 0;
      n = 0;
      while (cur < CAP && steps < entry_total && n < MAX_RESULTS) begin
        r.status = ST_ENTRY;
        r.slot = cur[SLOT_W-1:0];
        r.entry_key = table_key[cur[IDX_W-1:0]];
        r.entry_payload = table_payload[cur[IDX_W-1:0]];
        nxt = table_link[cur[IDX_W-1:0]];
        steps++;
        n++;
        r.last = !(nxt < CAP && steps < entry_total && n < MAX_RESULTS);
        expected_rsp_q.push_back(r);
        cur = nxt;
      end
    end
  endtask

  task automatic check_response();
    result_t want;
    if (expected_rsp_q.size() == 0) begin
      report_mismatch($sformatf("response with nothing expected: status %0d slot %0d",
                                rsp.status, rsp.slot));
    end else begin
      want = expected_rsp_q.pop_front();
      if (rsp.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
      if (rsp.slot !== want.slot)
        report_mismatch($sformatf("slot %0d, expected %0d", rsp.slot, want.slot));
      if (rsp.entry_key !== want.entry_key)
        report_mismatch($sformatf("entry_key %h, expected %h", rsp.entry_key,
                                  want.entry_key));
      if (rsp.entry_payload !== want.entry_payload)
        report_mismatch($sformatf("entry_payload %h, expected %h", rsp.entry_payload,
                                  want.entry_payload));
      if (rsp.last !== want.last)
        report_mismatch($sformatf("last %0d, expected %0d", rsp.last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head = END_SLOT;
      entry_total = 0;
      expected_rsp_q.delete();
    end else begin
      if (req.valid && req.ready) begin
        if (req.req_type == REQ_INSERT) predict_insert(req.key, req.payload);
        else predict_readout();
      end
      if (rsp.valid && rsp.ready) check_response();
    end
    pending <= expected_rsp_q.size();
    fail_count <= mismatch_total;
  end

endmodule

@@ sim/sorted_linked_list_insert_core_tb.sv @@
`timescale 1ns / 100ps
// testbench top for the sorted linked list insert core: clock, reset, request
// stimulus, response back-pressure and the verdict
// depends on slli_pkg, slli_if, the core and sorted_linked_list_insert_check
module sorted_linked_list_insert_core_tb;
  import slli_pkg::*;

  localparam int RUN_LIMIT    = 400000;
  localparam int RANDOM_ITEMS = 210;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   burst_left = 0;
  int   stall_mode = 0;
  int   mode_left = 0;
  int   run_left = 0;
  logic [KEY_W-1:0] used_keys[$];

  slli_req_if req_ch ();
  slli_rsp_if rsp_ch ();

  sorted_linked_list_insert_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sorted_linked_list_insert_check table_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: phases of always ready, coin-flip ready and runs of ready/stall
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_mode <= 0;
      mode_left <= 0;
      run_left <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(32, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (run_left == 0) begin
            rsp_ch.ready <= ~rsp_ch.ready;
            run_left <= $urandom_range(0, 7);
          end else begin
            run_left <= run_left - 1;
          end
        end
      endcase
    end
  end

  function automatic logic [KEY_W-1:0] name_key(input string s);
    logic [KEY_W-1:0] k;
    int               i;
    k = '0;
    for (i = 0; i < s.len() && i < 8; i++) k[63-8*i -: 8] = s[i];
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    int               len;
    int               i;
    k = '0;
    case ($urandom_range(0, 3))
      0: k = {$urandom, $urandom};
      1: begin
        len = $urandom_range(1, 8);
        for (i = 0; i < len; i++) k[63-8*i -: 8] = 8'($urandom_range(65, 90));
      end
      2: if (used_keys.size() > 0) k = used_keys[$urandom_range(0, used_keys.size() - 1)];
      default: begin
        k = 64'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) k = ~k;
      end
    endcase
    return k;
  endfunction

  // one transaction on req; the burst counter decides whether valid drops after it
  task automatic send_request(input logic rt, input logic [KEY_W-1:0] k,
                              input logic [PAYLOAD_W-1:0] p);
    req_ch.valid <= 1'b1;
    req_ch.req_type <= rt;
    req_ch.key <= k;
    req_ch.payload <= p;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_ch.valid <= 1'b0;
      burst_left = $urandom_range(0, 20);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_insert(input logic [KEY_W-1:0] k, input logic [PAYLOAD_W-1:0] p);
    used_keys.push_back(k);
    send_request(REQ_INSERT, k, p);
  endtask

  task automatic send_readout();
    send_request(REQ_READOUT, {$urandom, $urandom}, $urandom);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int i;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_INSERT;
    req_ch.key = '0;
    req_ch.payload = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty chain, then key and payload extremes with equal keys
    send_readout();
    send_insert('0, '0);
    send_insert('1, '1);
    send_insert('1, 32'h0000_0001);
    send_insert('0, 32'hdead_beef);
    send_readout();
    send_insert(name_key("BOB"), $urandom);
    send_insert(name_key("ALICE"), $urandom);
    send_insert(name_key("BOBBY"), $urandom);
    send_readout();
    // fill the table to capacity
    send_insert(name_key("CAROL"), $urandom);
    send_insert(name_key("ALICE"), $urandom);
    send_insert(name_key("A"), $urandom);
    send_insert(name_key("ZZZZZZZZ"), $urandom);
    send_insert(64'h8000_0000_0000_0000, $urandom);
    send_insert(64'h7fff_ffff_ffff_ffff, $urandom);
    send_insert(name_key("DAVE"), $urandom);
    send_insert(name_key("EVE"), $urandom);
    send_insert(name_key("BOB"), $urandom);
    send_readout();
    // table full
    send_insert('1, '1);
    send_readout();
    wait_drained();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if ($urandom_range(0, 99) < 55) send_readout();
      else send_insert(random_key(), $urandom);
    end

    wait_drained();
    repeat (CAPACITY_DEF + 8) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/slli_pkg.sv
src/slli_if.sv
src/slli_ram.sv
src/sorted_linked_list_insert_core.sv
sim/sorted_linked_list_insert_check.sv
sim/sorted_linked_list_insert_core_tb.sv
